// File: hw/rtl/pgve_pkg.sv
`default_nettype none

package pgve_pkg;

   localparam int POS_BITS_DEF   = 32;
   localparam int TIME_BITS_DEF  = 48;
   localparam int TIME_PORT_BITS = 48;
   localparam int POS_PORT_BITS  = 32;
   localparam int VEL_BITS       = 40;
   localparam int ACC_BITS       = 48;
   localparam int MIN_MOVE_BITS  = 10;
   localparam int SPEED_BITS     = 16;
   localparam int GATE_BITS      = 20;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;
   localparam int REACH_BITS     = 50;
   localparam int SCALE_BITS     = 20;

   localparam logic [SCALE_BITS-1:0]    PER_SECOND     = 20'd1000000;
   localparam logic [MIN_MOVE_BITS-1:0] MIN_MOVE_RESET = 10'd1;
   localparam logic [SPEED_BITS-1:0]    SPEED_RESET    = 16'd1000;
   localparam logic [GATE_BITS-1:0]     GATE_RESET     = 20'd1000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_MOVE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GATE     = 2'd2;

   typedef enum logic [1:0] {
      VERDICT_OK,
      VERDICT_SIMILAR,
      VERDICT_FAST,
      VERDICT_STEP
   } verdict_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CHECK,
      ST_REACH,
      ST_REACH_SQ,
      ST_VEL_MUL,
      ST_VEL_DIV,
      ST_ACC_MUL,
      ST_ACC_DIV,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/pose_gate_velocity_estimator.sv
// A request rejected at the first check (too similar or a bad time step) goes straight to
// its response; one at or past the gate distance runs a speed check that squares the reach
// unless it overflows, and an accepted request computes velocity then acceleration per axis.
// One request at a time: the next is taken in the idle state after a response is loaded,
// while that response waits; the bit-serial multiplier and divider do the arithmetic.
// Synchronous reset restores register defaults and zeroes the reference, velocity, accel.
`default_nettype none

module pose_gate_velocity_estimator
   import pgve_pkg::*;
#(
   parameter int POS_BITS  = POS_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [TIME_PORT_BITS-1:0]     req_time_us,
   input  wire logic signed [POS_PORT_BITS-1:0] req_pos_x,
   input  wire logic signed [POS_PORT_BITS-1:0] req_pos_y,
   input  wire logic signed [POS_PORT_BITS-1:0] req_pos_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_verdict,
   output logic signed [VEL_BITS-1:0]         rsp_vel_x,
   output logic signed [VEL_BITS-1:0]         rsp_vel_y,
   output logic signed [VEL_BITS-1:0]         rsp_vel_z,
   output logic signed [ACC_BITS-1:0]         rsp_acc_x,
   output logic signed [ACC_BITS-1:0]         rsp_acc_y,
   output logic signed [ACC_BITS-1:0]         rsp_acc_z,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int PW   = POS_BITS;
   localparam int TW   = TIME_BITS;
   localparam int AW0  = (PW + 1 > TW) ? PW + 1 : TW;
   localparam int AW1  = (AW0 > REACH_BITS) ? AW0 : REACH_BITS;
   localparam int AW   = (AW1 > VEL_BITS + 1) ? AW1 : VEL_BITS + 1;
   localparam int BW   = (PW + 1 > REACH_BITS) ? PW + 1 : REACH_BITS;
   localparam int PRW  = AW + BW;
   localparam int MCW  = $clog2(BW + 1);
   localparam int DSW  = 2 * (PW + 1) + 2;
   localparam int GW   = (DSW > 2 * GATE_BITS) ? DSW : 2 * GATE_BITS;
   localparam int NW0  = PW + 1 + SCALE_BITS;
   localparam int NW1  = VEL_BITS + 1 + SCALE_BITS;
   localparam int NW   = (NW0 > NW1) ? NW0 : NW1;
   localparam logic [VEL_BITS-1:0] VEL_LIM = {1'b1, {(VEL_BITS - 1){1'b0}}};
   localparam logic [ACC_BITS-1:0] ACC_LIM = {1'b1, {(ACC_BITS - 1){1'b0}}};

   function automatic logic [VEL_BITS-1:0] sat_vel(input logic [NW-1:0] q, input logic neg);
      logic [VEL_BITS-1:0] m;
      m = (q > NW'(VEL_LIM)) ? VEL_LIM : q[VEL_BITS-1:0];
      if (neg) begin
         return ~m + VEL_BITS'(1);
      end
      return (m == VEL_LIM) ? VEL_LIM - VEL_BITS'(1) : m;
   endfunction

   function automatic logic [ACC_BITS-1:0] sat_acc(input logic [NW-1:0] q, input logic neg);
      logic [ACC_BITS-1:0] m;
      m = (q > NW'(ACC_LIM)) ? ACC_LIM : q[ACC_BITS-1:0];
      if (neg) begin
         return ~m + ACC_BITS'(1);
      end
      return (m == ACC_LIM) ? ACC_LIM - ACC_BITS'(1) : m;
   endfunction

   state_type state_ff, state_in;
   logic      launch_ff, launch_in;
   logic [1:0] axis_ff, axis_in;

   logic [MIN_MOVE_BITS-1:0] min_move_ff, min_move_in;
   logic [SPEED_BITS-1:0]    speed_ff, speed_in;
   logic [GATE_BITS-1:0]     gate_ff, gate_in;

   logic [TW-1:0]  t_ff, t_in;
   logic [TW-1:0]  last_time_ff, last_time_in;
   logic [TW-1:0]  dt_ff, dt_in;
   logic [PW-1:0]  pos_ff [3];
   logic [PW-1:0]  pos_in [3];
   logic [PW-1:0]  last_pos_ff [3];
   logic [PW-1:0]  last_pos_in [3];
   logic [PW:0]    delta_ff [3];
   logic [PW:0]    delta_in [3];
   logic [DSW-1:0] dist_ff, dist_in;
   logic [REACH_BITS-1:0] reach_ff, reach_in;
   verdict_type    verdict_ff, verdict_in;
   logic [VEL_BITS-1:0] vnew_ff, vnew_in;
   logic [VEL_BITS-1:0] vel_ff [3];
   logic [VEL_BITS-1:0] vel_in [3];
   logic [ACC_BITS-1:0] acc_ff [3];
   logic [ACC_BITS-1:0] acc_in [3];

   logic                rsp_valid_ff, rsp_valid_in;
   verdict_type         rsp_verdict_ff, rsp_verdict_in;
   logic [VEL_BITS-1:0] rsp_vel_ff [3];
   logic [VEL_BITS-1:0] rsp_vel_in [3];
   logic [ACC_BITS-1:0] rsp_acc_ff [3];
   logic [ACC_BITS-1:0] rsp_acc_in [3];

   logic [PW-1:0]   req_pos [3];
   logic [PW:0]     delta_sel;
   logic [PW:0]     mag_delta;
   logic [VEL_BITS:0] vdiff;
   logic [VEL_BITS:0] mag_diff;
   logic [2*MIN_MOVE_BITS-1:0] min2;
   logic [2*GATE_BITS-1:0]     gate2;
   logic            too_similar, step_bad, gated, reach_big, too_fast, rsp_free;

   logic           mul_start, mul_done;
   logic [AW-1:0]  mul_a;
   logic [BW-1:0]  mul_b;
   logic [MCW-1:0] mul_n;
   logic [PRW-1:0] mul_prod;
   logic           div_start, div_done;
   logic [NW-1:0]  div_quot;

   assign req_pos[0] = PW'($unsigned(req_pos_x));
   assign req_pos[1] = PW'($unsigned(req_pos_y));
   assign req_pos[2] = PW'($unsigned(req_pos_z));

   assign delta_sel = delta_ff[axis_ff];
   assign mag_delta = delta_sel[PW] ? ~delta_sel + (PW + 1)'(1) : delta_sel;
   assign vdiff     = {vnew_ff[VEL_BITS-1], vnew_ff}
                    - {vel_ff[axis_ff][VEL_BITS-1], vel_ff[axis_ff]};
   assign mag_diff  = vdiff[VEL_BITS] ? ~vdiff + (VEL_BITS + 1)'(1) : vdiff;
   assign min2      = min_move_ff * min_move_ff;
   assign gate2     = gate_ff * gate_ff;
   assign too_similar = GW'(dist_ff) < GW'(min2);
   assign step_bad    = t_ff <= last_time_ff;
   assign gated       = GW'(dist_ff) >= GW'(gate2);
   assign reach_big   = |mul_prod[PRW-1:REACH_BITS];
   assign too_fast    = mul_prod < PRW'(dist_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   pgve_smul #(.AW(AW), .BW(BW), .PRW(PRW), .CW(MCW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .nbits (mul_n),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   pgve_sdiv #(.NW(NW), .DW(TW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (NW'(mul_prod)),
      .den   (dt_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done && axis_ff == 2'd2) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (too_similar || step_bad) begin
               state_in = ST_RESP;
            end else if (gated) begin
               state_in = ST_REACH;
            end else begin
               state_in = ST_VEL_MUL;
            end
         end
         ST_REACH: begin
            if (mul_done) begin
               state_in = reach_big ? ST_VEL_MUL : ST_REACH_SQ;
            end
         end
         ST_REACH_SQ: begin
            if (mul_done) begin
               state_in = too_fast ? ST_RESP : ST_VEL_MUL;
            end
         end
         ST_VEL_MUL: begin
            if (mul_done) begin
               state_in = ST_VEL_DIV;
            end
         end
         ST_VEL_DIV: begin
            if (div_done) begin
               state_in = ST_ACC_MUL;
            end
         end
         ST_ACC_MUL: begin
            if (mul_done) begin
               state_in = ST_ACC_DIV;
            end
         end
         ST_ACC_DIV: begin
            if (div_done) begin
               state_in = (axis_ff == 2'd2) ? ST_RESP : ST_VEL_MUL;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mul_n     = MCW'(1);
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SQUARE: begin
            mul_start = launch_ff;
            mul_a     = AW'(mag_delta);
            mul_b     = BW'(mag_delta);
            mul_n     = MCW'(PW + 1);
         end
         ST_REACH: begin
            mul_start = launch_ff;
            mul_a     = AW'(dt_ff);
            mul_b     = BW'(speed_ff);
            mul_n     = MCW'(SPEED_BITS);
         end
         ST_REACH_SQ: begin
            mul_start = launch_ff;
            mul_a     = AW'(reach_ff);
            mul_b     = BW'(reach_ff);
            mul_n     = MCW'(REACH_BITS);
         end
         ST_VEL_MUL: begin
            mul_start = launch_ff;
            mul_a     = AW'(mag_delta);
            mul_b     = BW'(PER_SECOND);
            mul_n     = MCW'(SCALE_BITS);
         end
         ST_ACC_MUL: begin
            mul_start = launch_ff;
            mul_a     = AW'(mag_diff);
            mul_b     = BW'(PER_SECOND);
            mul_n     = MCW'(SCALE_BITS);
         end
         ST_VEL_DIV, ST_ACC_DIV: div_start = launch_ff;
         ST_CHECK, ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      launch_in      = (state_in != state_ff) || (state_ff == ST_SQUARE && mul_done);
      axis_in        = axis_ff;
      min_move_in    = min_move_ff;
      speed_in       = speed_ff;
      gate_in        = gate_ff;
      t_in           = t_ff;
      last_time_in   = last_time_ff;
      dt_in          = dt_ff;
      pos_in         = pos_ff;
      last_pos_in    = last_pos_ff;
      delta_in       = delta_ff;
      dist_in        = dist_ff;
      reach_in       = reach_ff;
      verdict_in     = verdict_ff;
      vnew_in        = vnew_ff;
      vel_in         = vel_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_vel_in     = rsp_vel_ff;
      rsp_acc_in     = rsp_acc_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_MOVE: min_move_in = csr_data[MIN_MOVE_BITS-1:0];
            CSR_SPEED:    speed_in    = csr_data[SPEED_BITS-1:0];
            CSR_GATE:     gate_in     = csr_data[GATE_BITS-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               t_in       = TW'(req_time_us);
               axis_in    = 2'd0;
               dist_in    = '0;
               verdict_in = VERDICT_OK;
               for (int i = 0; i < 3; i++) begin
                  pos_in[i]   = req_pos[i];
                  delta_in[i] = {req_pos[i][PW-1], req_pos[i]}
                              - {last_pos_ff[i][PW-1], last_pos_ff[i]};
               end
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               dist_in = dist_ff + DSW'(mul_prod);
               axis_in = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            end
         end
         ST_CHECK: begin
            dt_in = t_ff - last_time_ff;
            if (too_similar) begin
               verdict_in = VERDICT_SIMILAR;
            end else if (step_bad) begin
               verdict_in = VERDICT_STEP;
            end
         end
         ST_REACH: begin
            if (mul_done) begin
               reach_in = mul_prod[REACH_BITS-1:0];
            end
         end
         ST_REACH_SQ: begin
            if (mul_done && too_fast) begin
               verdict_in = VERDICT_FAST;
            end
         end
         ST_VEL_DIV: begin
            if (div_done) begin
               vnew_in = sat_vel(div_quot, delta_sel[PW]);
            end
         end
         ST_ACC_DIV: begin
            if (div_done) begin
               acc_in[axis_ff]      = sat_acc(div_quot, vdiff[VEL_BITS]);
               vel_in[axis_ff]      = vnew_ff;
               last_pos_in[axis_ff] = pos_ff[axis_ff];
               if (axis_ff == 2'd2) begin
                  last_time_in = t_ff;
                  axis_in      = 2'd0;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_vel_in     = vel_ff;
               rsp_acc_in     = acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         axis_ff      <= 2'd0;
         min_move_ff  <= MIN_MOVE_RESET;
         speed_ff     <= SPEED_RESET;
         gate_ff      <= GATE_RESET;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            last_pos_ff[i] <= '0;
            vel_ff[i]      <= '0;
            acc_ff[i]      <= '0;
         end
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         axis_ff      <= axis_in;
         min_move_ff  <= min_move_in;
         speed_ff     <= speed_in;
         gate_ff      <= gate_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
         last_pos_ff  <= last_pos_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
      end
      t_ff           <= t_in;
      dt_ff          <= dt_in;
      pos_ff         <= pos_in;
      delta_ff       <= delta_in;
      dist_ff        <= dist_in;
      reach_ff       <= reach_in;
      verdict_ff     <= verdict_in;
      vnew_ff        <= vnew_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_vel_ff     <= rsp_vel_in;
      rsp_acc_ff     <= rsp_acc_in;
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_vel_x   = rsp_vel_ff[0];
   assign rsp_vel_y   = rsp_vel_ff[1];
   assign rsp_vel_z   = rsp_vel_ff[2];
   assign rsp_acc_x   = rsp_acc_ff[0];
   assign rsp_acc_y   = rsp_acc_ff[1];
   assign rsp_acc_z   = rsp_acc_ff[2];

endmodule

`default_nettype wire

// File: hw/rtl/pgve_smul.sv
`default_nettype none

module pgve_smul #(
   parameter int AW  = 64,
   parameter int BW  = 50,
   parameter int PRW = AW + BW,
   parameter int CW  = $clog2(BW + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [AW-1:0]  a,
   input  wire logic [BW-1:0]  b,
   input  wire logic [CW-1:0]  nbits,
   output logic                done,
   output logic [PRW-1:0]      prod
);

   logic [PRW-1:0] a_ff, a_in;
   logic [BW-1:0]  b_ff, b_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == CW'(1));
      if (start) begin
         a_in    = PRW'(a);
         b_in    = b;
         prod_in = '0;
         cnt_in  = nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            prod_in = prod_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pgve_sdiv.sv
`default_nettype none

module pgve_sdiv #(
   parameter int NW = 61,
   parameter int DW = 48,
   parameter int CW = $clog2(NW + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quot
);

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quot_ff, quot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          fits;

   assign trial = {rem_ff, num_ff[NW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == CW'(1));
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         quot_in = {quot_ff[NW-2:0], fits};
         num_in  = num_ff << 1;
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire
